// File: design/rdct_pkg.sv
// rdct_pkg: shared types and constants for the range divisor count tree
// no dependencies; imported by range_divisor_count_tree_unit
package rdct_pkg;

    // default sizing of the tree and the element values
    localparam int DEF_MAX_ELEMENTS = 65536;
    localparam int DEF_VALUE_BITS   = 30;

    // fixed port widths
    localparam int POS_W   = 17;
    localparam int ELEM_W  = 30;
    localparam int LEN_W   = 17;
    localparam int REM_W   = 17;

    localparam logic [LEN_W-1:0] LEN_RESET = 17'd65536;
    localparam logic [31:0]      SPAN_SAT  = 32'd131071;

    // item opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_LEAF,
        S_LD_UP,
        S_LD_RDR,
        S_LD_CAPB,
        S_LD_WB,
        S_MG_START,
        S_MG_DIV,
        S_MG_CHK,
        S_Q_LO,
        S_Q_LOC,
        S_Q_HI,
        S_Q_HIC,
        S_Q_SHIFT,
        S_Q_DONE,
        S_OUT
    } t_state;

    // where a merge hands control back
    typedef enum logic [1:0] {
        RET_LOAD,
        RET_QLO,
        RET_QHI
    } t_ret;

endpackage

// File: design/range_divisor_count_tree_unit.sv
// range_divisor_count_tree_unit: segment tree of "divides all" nodes with
// one shared bit-serial modulo unit under a small sequencer
// depends on rdct_pkg
//
// Usage
//   Input channel i_in_valid/o_in_ready carries one item: op 0 loads
//   element_value at position, op 1 queries range_start..range_end.
//   Output channel o_out_valid/i_out_ready returns one item per query
//   (remaining, range_error); loads return nothing.
//   i_cfg_we writes the length register from i_cfg_wdata.
// Timing
//   One item at a time; o_in_ready is high only while the sequencer idles.
//   A load walks log2(MAX_ELEMENTS) levels, each with node memory
//   access plus up to two modulo passes. A query visits up to two nodes
//   per level with the same merge cost. Error and out-of-range queries
//   raise o_out_valid the cycle after the item is taken. The modulo unit
//   sets the pace.
// Reset and stall
//   Reset returns the sequencer to idle and length to 65536; the node
//   memory is not cleared, every position must be loaded before a query.
//   A stalled result holds in its output register and no new item is taken.
module range_divisor_count_tree_unit
    import rdct_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_op,
    input  logic [POS_W-1:0]  i_position,
    input  logic [ELEM_W-1:0] i_element_value,
    input  logic [POS_W-1:0]  i_range_start,
    input  logic [POS_W-1:0]  i_range_end,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [REM_W-1:0]  o_remaining,
    output logic              o_range_error
);

    localparam int VB    = VALUE_BITS;
    localparam int CW    = $clog2(MAX_ELEMENTS) + 1;
    localparam int AW    = $clog2(MAX_ELEMENTS) + 1;
    localparam int QW    = AW + 1;
    localparam int DEPTH = 2 * MAX_ELEMENTS;
    localparam int SW    = $clog2(MAX_ELEMENTS + 1);
    localparam int SCW   = $clog2(VB + 1);

    typedef struct packed {
        logic          none;
        logic [CW-1:0] cnt;
        logic [VB-1:0] val;
    } t_node;

    // control and datapath registers
    t_state          r_state, n_state;
    t_ret            r_ret, n_ret;
    logic [LEN_W-1:0] r_len;
    logic [AW-1:0]   r_idx, n_idx;
    logic [QW-1:0]   r_lo, n_lo, r_hi, n_hi;
    logic            r_have, n_have;
    t_node           r_a, n_a, r_b, n_b, r_acc, n_acc;
    logic [SW-1:0]   r_span, n_span;
    logic            r_pass, n_pass;
    logic [VB-1:0]   r_x, n_x, r_d, n_d, r_rem, n_rem;
    logic [SCW-1:0]  r_scnt, n_scnt;
    logic [REM_W-1:0] r_remaining, n_remaining;
    logic            r_err, n_err;

    // node memory
    t_node           mem [DEPTH];
    t_node           r_rd;
    logic [AW-1:0]   rd_addr, wr_addr;
    logic            wr_en;
    t_node           wr_data;

    // decode helpers
    logic [31:0] pos32, st32, en32, eff32, span32, leaf32, lo32, hi32, cnt32, rem32;
    logic [VB+ELEM_W-1:0] elem_ext;
    logic [VB:0]  div_t;
    logic         in_acc;

    assign in_acc   = i_in_valid && o_in_ready;
    assign pos32    = {{(32-POS_W){1'b0}}, i_position};
    assign st32     = {{(32-POS_W){1'b0}}, i_range_start};
    assign en32     = {{(32-POS_W){1'b0}}, i_range_end};
    assign eff32    = ({{(32-LEN_W){1'b0}}, r_len} > 32'(MAX_ELEMENTS)) ?
                      32'(MAX_ELEMENTS) : {{(32-LEN_W){1'b0}}, r_len};
    assign span32   = en32 - st32 + 32'd1;
    assign leaf32   = 32'(MAX_ELEMENTS) + pos32 - 32'd1;
    assign lo32     = 32'(MAX_ELEMENTS) + st32 - 32'd1;
    assign hi32     = 32'(MAX_ELEMENTS) + en32;
    assign elem_ext = {{VB{1'b0}}, i_element_value};
    assign cnt32    = r_have ? {{(32-CW){1'b0}}, r_acc.cnt} : 32'd0;
    assign rem32    = {{(32-SW){1'b0}}, r_span};

    // one restoring step of the shared modulo unit
    assign div_t = {r_rem, r_x[VB-1]};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_op == OP_LOAD) begin
                        if (pos32 != 32'd0 && pos32 <= 32'(MAX_ELEMENTS)) begin
                            n_state = S_LD_LEAF;
                        end
                    end else if (st32 > en32 || st32 < 32'd1 || en32 > eff32) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_Q_LO;
                    end
                end
            end
            S_LD_LEAF: n_state = S_LD_UP;
            S_LD_UP:   n_state = (r_idx <= AW'(1)) ? S_IDLE : S_LD_RDR;
            S_LD_RDR:  n_state = S_LD_CAPB;
            S_LD_CAPB: n_state = S_MG_START;
            S_LD_WB:   n_state = S_LD_UP;
            S_MG_START: begin
                if (r_a.none || r_b.none || r_a.val == r_b.val) begin
                    case (r_ret)
                        RET_LOAD: n_state = S_LD_WB;
                        RET_QLO:  n_state = S_Q_HI;
                        default:  n_state = S_Q_SHIFT;
                    endcase
                end else begin
                    n_state = S_MG_DIV;
                end
            end
            S_MG_DIV:  n_state = (r_scnt == SCW'(1)) ? S_MG_CHK : S_MG_DIV;
            S_MG_CHK: begin
                if (r_rem != '0 && !r_pass) begin
                    n_state = S_MG_DIV;
                end else begin
                    case (r_ret)
                        RET_LOAD: n_state = S_LD_WB;
                        RET_QLO:  n_state = S_Q_HI;
                        default:  n_state = S_Q_SHIFT;
                    endcase
                end
            end
            S_Q_LO: begin
                if (r_lo >= r_hi)  n_state = S_Q_DONE;
                else if (r_lo[0])  n_state = S_Q_LOC;
                else               n_state = S_Q_HI;
            end
            S_Q_LOC:   n_state = r_have ? S_MG_START : S_Q_HI;
            S_Q_HI:    n_state = r_hi[0] ? S_Q_HIC : S_Q_SHIFT;
            S_Q_HIC:   n_state = r_have ? S_MG_START : S_Q_SHIFT;
            S_Q_SHIFT: n_state = S_Q_LO;
            S_Q_DONE:  n_state = S_OUT;
            S_OUT:     n_state = i_out_ready ? S_IDLE : S_OUT;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_ret       = r_ret;
        n_idx       = r_idx;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_have      = r_have;
        n_a         = r_a;
        n_b         = r_b;
        n_acc       = r_acc;
        n_span      = r_span;
        n_pass      = r_pass;
        n_x         = r_x;
        n_d         = r_d;
        n_rem       = r_rem;
        n_scnt      = r_scnt;
        n_remaining = r_remaining;
        n_err       = r_err;
        rd_addr     = r_idx;
        wr_addr     = r_idx;
        wr_en       = 1'b0;
        wr_data     = r_acc;
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT);
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_op == OP_LOAD) begin
                        n_idx     = leaf32[AW-1:0];
                        n_a.none  = 1'b0;
                        n_a.cnt   = CW'(1);
                        n_a.val   = elem_ext[VB-1:0];
                        n_ret     = RET_LOAD;
                    end else if (st32 > en32) begin
                        n_remaining = '0;
                        n_err       = 1'b1;
                    end else if (st32 < 32'd1 || en32 > eff32) begin
                        n_remaining = (span32 > SPAN_SAT) ? SPAN_SAT[REM_W-1:0] :
                                      span32[REM_W-1:0];
                        n_err       = 1'b0;
                    end else begin
                        n_lo   = lo32[QW-1:0];
                        n_hi   = hi32[QW-1:0];
                        n_have = 1'b0;
                        n_span = span32[SW-1:0];
                        n_err  = 1'b0;
                    end
                end
            end
            // leaf write from the staged node
            S_LD_LEAF: begin
                wr_en   = 1'b1;
                wr_data = r_a;
            end
            // step to the parent and fetch its left child
            S_LD_UP: begin
                rd_addr = {r_idx[AW-1:1], 1'b0};
                n_idx   = r_idx >> 1;
            end
            S_LD_RDR: begin
                rd_addr = {r_idx[AW-2:0], 1'b1};
                n_a     = r_rd;
            end
            S_LD_CAPB: n_b = r_rd;
            S_LD_WB: begin
                wr_en   = 1'b1;
                wr_data = r_acc;
            end
            // merge: none, equal values, or start the first modulo pass
            S_MG_START: begin
                if (r_a.none || r_b.none) begin
                    n_acc      = '0;
                    n_acc.none = 1'b1;
                end else if (r_a.val == r_b.val) begin
                    n_acc     = r_a;
                    n_acc.cnt = r_a.cnt + r_b.cnt;
                end else begin
                    n_x    = r_b.val;
                    n_d    = r_a.val;
                    n_rem  = '0;
                    n_scnt = SCW'(VB);
                    n_pass = 1'b0;
                end
            end
            // restoring modulo, one bit per cycle; divisor 0 leaves x itself
            S_MG_DIV: begin
                n_rem  = (div_t >= {1'b0, r_d}) ? VB'(div_t - {1'b0, r_d}) : div_t[VB-1:0];
                n_x    = r_x << 1;
                n_scnt = r_scnt - SCW'(1);
            end
            S_MG_CHK: begin
                if (r_rem == '0) begin
                    n_acc = r_pass ? r_b : r_a;
                end else if (!r_pass) begin
                    n_x    = r_a.val;
                    n_d    = r_b.val;
                    n_rem  = '0;
                    n_scnt = SCW'(VB);
                    n_pass = 1'b1;
                end else begin
                    n_acc      = '0;
                    n_acc.none = 1'b1;
                end
            end
            // query walk, left edge
            S_Q_LO: begin
                rd_addr = r_lo[AW-1:0];
                if (r_lo < r_hi && r_lo[0]) begin
                    n_lo = r_lo + QW'(1);
                end
            end
            S_Q_LOC: begin
                n_ret = RET_QLO;
                if (r_have) begin
                    n_a = r_acc;
                    n_b = r_rd;
                end else begin
                    n_acc  = r_rd;
                    n_have = 1'b1;
                end
            end
            // query walk, right edge
            S_Q_HI: begin
                rd_addr = AW'(r_hi - QW'(1));
                if (r_hi[0]) begin
                    n_hi = r_hi - QW'(1);
                end
            end
            S_Q_HIC: begin
                n_ret = RET_QHI;
                if (r_have) begin
                    n_a = r_acc;
                    n_b = r_rd;
                end else begin
                    n_acc  = r_rd;
                    n_have = 1'b1;
                end
            end
            S_Q_SHIFT: begin
                n_lo = r_lo >> 1;
                n_hi = r_hi >> 1;
            end
            S_Q_DONE: begin
                n_remaining = (cnt32 <= rem32) ? REM_W'(rem32 - cnt32) : '0;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= RET_LOAD;
            r_len   <= LEN_RESET;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_have      <= n_have;
        r_a         <= n_a;
        r_b         <= n_b;
        r_acc       <= n_acc;
        r_span      <= n_span;
        r_pass      <= n_pass;
        r_x         <= n_x;
        r_d         <= n_d;
        r_rem       <= n_rem;
        r_scnt      <= n_scnt;
        r_remaining <= n_remaining;
        r_err       <= n_err;
    end

    // node memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    assign o_remaining   = r_remaining;
    assign o_range_error = r_err;

    // checks
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> o_remaining == '0)
        else $error("range error with nonzero remaining");

    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MG_DIV |-> r_scnt != '0 && r_scnt <= SCW'(VB))
        else $error("modulo step count out of range");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while result pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_remaining))
        else $error("result dropped under stall");

endmodule
